// ----- rtl/jerk_limited_line_profile_defines.svh -----
// Assertion macros for the jerk-limited line profile checker.
`ifndef JERK_LIMITED_LINE_PROFILE_DEFINES_SVH
`define JERK_LIMITED_LINE_PROFILE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define JLP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("jlp check failed");

// Next-cycle implication, clocked on clk_i, off during reset.
`define JLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jlp check failed");

`endif

// ----- rtl/jlp_pkg.sv -----
// Types, constants and arithmetic helpers shared by the line profile modules.
package jlp_pkg;

  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned DIV_STEPS       = 4;
  localparam int unsigned DISP_W          = 33;
  localparam int unsigned CFG_W           = 31;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned NUM_AXES        = 3;

  localparam logic [1:0] CFG_VEL  = 2'd0;
  localparam logic [1:0] CFG_ACC  = 2'd1;
  localparam logic [1:0] CFG_JERK = 2'd2;

  localparam logic [2:0] SEG_LAST = 3'd6;
  localparam logic [1:0] AX_LAST  = 2'd2;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {DUR_T1, DUR_T2, DUR_T4} dur_sel_e;
  typedef enum logic [1:0] {JS_POS, JS_ZERO, JS_NEG} jerk_sign_e;
  typedef enum logic [2:0] {DV_SX, DV_SY, DV_SZ, DV_T1, DV_T2, DV_T4} div_sel_e;
  typedef enum logic [2:0] {F_IDLE, F_LOAD, F_WAIT, F_JAX, F_J6, F_PUSH} front_e;
  typedef enum logic [2:0] {B_IDLE, B_TT, B_TTT, B_MUL, B_DIV, B_ADD} back_e;

  typedef logic [NUM_AXES-1:0][DATA_W-1:0] vec3_t;

  typedef struct packed {
    vec3_t pos;
    vec3_t jax;
    vec3_t jax6;
    vec3_t dur;
  } job_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'(Q_MAX)) begin
      r = Q_MAX;
    end else if (x < 64'(Q_MIN)) begin
      r = Q_MIN;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input int unsigned frac);
    logic signed [63:0] p;
    logic signed [63:0] bias;
    p = 64'(a) * 64'(b);
    bias = p[63] ? ((64'sd1 <<< frac) - 64'sd1) : 64'sd0;
    return sat32((p + bias) >>> frac);
  endfunction

  function automatic logic signed [31:0] div6(input logic signed [31:0] x);
    logic [31:0] m;
    logic [65:0] pr;
    logic [31:0] q;
    m  = x[31] ? (~x + 32'd1) : x;
    pr = {34'd0, m} * {34'd0, 32'hAAAA_AAAB};
    q  = {2'b00, pr[63:34]};
    return x[31] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [31:0] half(input logic signed [31:0] x);
    return (x + $signed({31'd0, x[31]})) >>> 1;
  endfunction

  function automatic dur_sel_e dur_sel(input logic [2:0] seg);
    dur_sel_e r;
    case (seg)
      3'd1, 3'd5: r = DUR_T2;
      3'd3:       r = DUR_T4;
      default:    r = DUR_T1;
    endcase
    return r;
  endfunction

  function automatic jerk_sign_e jerk_sign(input logic [2:0] seg);
    jerk_sign_e r;
    case (seg)
      3'd0, 3'd6: r = JS_POS;
      3'd2, 3'd4: r = JS_NEG;
      default:    r = JS_ZERO;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/jerk_limited_line_profile.sv -----
// Each request yields 21 results, seven segments of three axes, the last one marked.
// Planning runs six divisions in the shared divider (4 quotient bits per cycle), and the
// back end emits the 21 results while the front plans the next request.
// Reset: asynchronous, active low; clears control state and loads the default limits.
// A queue of QUEUE_DEPTH planned requests lets intake run ahead of result output.
module jerk_limited_line_profile import jlp_pkg::*; #(
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [31:0]      start_x_i,
  input  logic [31:0]      start_y_i,
  input  logic [31:0]      start_z_i,
  input  logic [31:0]      end_x_i,
  input  logic [31:0]      end_y_i,
  input  logic [31:0]      end_z_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       segment_o,
  output logic [1:0]       axis_o,
  output logic [31:0]      pos_coeff_o,
  output logic [31:0]      vel_coeff_o,
  output logic [31:0]      acc_coeff_o,
  output logic [31:0]      jerk_coeff_o,
  output logic [31:0]      duration_o,
  output logic             last_o
);

  logic [CFG_W-1:0] vel_limit_q, acc_limit_q, jerk_limit_q;
  logic push, full, pop, empty;
  job_t job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_limit_q  <= CFG_W'(131072);
      acc_limit_q  <= CFG_W'(65536);
      jerk_limit_q <= CFG_W'(262144);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VEL:  vel_limit_q  <= cfg_data_i;
        CFG_ACC:  acc_limit_q  <= cfg_data_i;
        CFG_JERK: jerk_limit_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  jlp_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .start_z_i   (start_z_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .end_z_i     (end_z_i),
    .vel_limit_i (vel_limit_q),
    .acc_limit_i (acc_limit_q),
    .jerk_limit_i(jerk_limit_q),
    .push_o      (push),
    .job_o       (job_in),
    .full_i      (full)
  );

  jlp_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (job_out)
  );

  jlp_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .segment_o   (segment_o),
    .axis_o      (axis_o),
    .pos_coeff_o (pos_coeff_o),
    .vel_coeff_o (vel_coeff_o),
    .acc_coeff_o (acc_coeff_o),
    .jerk_coeff_o(jerk_coeff_o),
    .duration_o  (duration_o),
    .last_o      (last_o)
  );

endmodule

// ----- rtl/jlp_div.sv -----
// Iterative unsigned restoring divider, several quotient bits per cycle.
module jlp_div import jlp_pkg::*; #(
  parameter int unsigned NUM_W = 49,
  parameter int unsigned DEN_W = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned ITER  = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned PAD_W = ITER * DIV_STEPS;
  localparam int unsigned CNT_W = $clog2(ITER + 1);

  logic [PAD_W-1:0] sh_q, sh_d;
  logic [DEN_W:0]   rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;

  always_comb begin
    logic [DEN_W:0]   r;
    logic [PAD_W-1:0] s;
    r = rem_q;
    s = sh_q;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r = {r[DEN_W-1:0], s[PAD_W-1]};
      s = {s[PAD_W-2:0], 1'b0};
      if (r >= {1'b0, den_q}) begin
        r    = r - {1'b0, den_q};
        s[0] = 1'b1;
      end
    end
    rem_d = r;
    sh_d  = s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(ITER);
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1));
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= PAD_W'(num_i);
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      sh_q  <= sh_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = sh_q[NUM_W-1:0];

endmodule

// ----- rtl/jlp_front.sv -----
// Request intake: displacement, axis scales, segment times and axis jerks.
module jlp_front import jlp_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [31:0]       start_x_i,
  input  logic [31:0]       start_y_i,
  input  logic [31:0]       start_z_i,
  input  logic [31:0]       end_x_i,
  input  logic [31:0]       end_y_i,
  input  logic [31:0]       end_z_i,
  input  logic [CFG_W-1:0]  vel_limit_i,
  input  logic [CFG_W-1:0]  acc_limit_i,
  input  logic [CFG_W-1:0]  jerk_limit_i,
  output logic              push_o,
  output job_t              job_o,
  input  logic              full_i
);

  localparam int unsigned NUM_W = DISP_W + FRAC_BITS;
  localparam int unsigned QV_W  = NUM_W + 3;

  front_e state_q, state_d;
  div_sel_e k_q;

  logic                          ib_valid_q;
  vec3_t                         ib_s_q, ib_e_q;
  vec3_t                         pos_q, sc_q, jax_q, jax6_q, dur_q;
  logic [NUM_AXES-1:0]           dneg_q;
  logic [NUM_AXES-1:0][DISP_W-1:0] dabs_q;
  logic [DISP_W-1:0]             max_q;

  logic                          pull, div_start, div_done;
  logic [NUM_W-1:0]              div_num, div_quo;
  logic [DISP_W-1:0]             div_den;
  logic signed [QV_W-1:0]        qv;
  logic signed [63:0]            qv64, d0_64, d1_64;
  vec3_t                         in_s, in_e;
  logic [NUM_AXES-1:0][DISP_W-1:0] abs_d;
  logic [NUM_AXES-1:0]           neg_d;
  logic [DISP_W-1:0]             max_d;

  assign in_s = {start_z_i, start_y_i, start_x_i};
  assign in_e = {end_z_i, end_y_i, end_x_i};

  always_comb begin
    logic signed [DISP_W-1:0] d;
    max_d = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      d        = $signed({ib_e_q[i][31], ib_e_q[i]}) - $signed({ib_s_q[i][31], ib_s_q[i]});
      neg_d[i] = d[DISP_W-1];
      abs_d[i] = d[DISP_W-1] ? -d : d;
      if (abs_d[i] > max_d) begin
        max_d = abs_d[i];
      end
    end
  end

  always_comb begin
    case (k_q)
      DV_SX: begin
        div_num = NUM_W'(dabs_q[0]) << FRAC_BITS;
        div_den = max_q;
      end
      DV_SY: begin
        div_num = NUM_W'(dabs_q[1]) << FRAC_BITS;
        div_den = max_q;
      end
      DV_SZ: begin
        div_num = NUM_W'(dabs_q[2]) << FRAC_BITS;
        div_den = max_q;
      end
      DV_T1: begin
        div_num = NUM_W'(acc_limit_i) << FRAC_BITS;
        div_den = DISP_W'(jerk_limit_i);
      end
      DV_T2: begin
        div_num = NUM_W'(vel_limit_i) << FRAC_BITS;
        div_den = DISP_W'(acc_limit_i);
      end
      default: begin
        div_num = NUM_W'(max_q) << FRAC_BITS;
        div_den = DISP_W'(vel_limit_i);
      end
    endcase
  end

  assign qv    = (div_den == '0) ? QV_W'(Q_MAX) : $signed({3'b000, div_quo});
  assign qv64  = 64'(qv);
  assign d0_64 = 64'($signed(dur_q[0]));
  assign d1_64 = 64'($signed(dur_q[1]));

  jlp_div #(
    .NUM_W(NUM_W),
    .DEN_W(DISP_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (ib_valid_q) begin
        state_d = F_LOAD;
      end
      F_LOAD: state_d = F_WAIT;
      F_WAIT: if (div_done) begin
        state_d = (k_q == DV_T4) ? F_JAX : F_LOAD;
      end
      F_JAX:  state_d = F_J6;
      F_J6:   state_d = F_PUSH;
      F_PUSH: if (!full_i) begin
        state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    pull       = (state_q == F_IDLE) && ib_valid_q;
    div_start  = (state_q == F_LOAD);
    push_o     = (state_q == F_PUSH) && !full_i;
    in_stall_o = ib_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_IDLE;
      ib_valid_q <= 1'b0;
      k_q        <= DV_SX;
    end else begin
      state_q <= state_d;
      if (in_valid_i && !ib_valid_q) begin
        ib_valid_q <= 1'b1;
      end else if (pull) begin
        ib_valid_q <= 1'b0;
      end
      if (pull) begin
        k_q <= DV_SX;
      end else if (state_q == F_WAIT && div_done && k_q != DV_T4) begin
        k_q <= div_sel_e'(k_q + 3'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !ib_valid_q) begin
      ib_s_q <= in_s;
      ib_e_q <= in_e;
    end
    if (pull) begin
      pos_q  <= ib_s_q;
      dneg_q <= neg_d;
      dabs_q <= abs_d;
      max_q  <= max_d;
    end
    if (state_q == F_WAIT && div_done) begin
      case (k_q)
        DV_SX, DV_SY, DV_SZ: begin
          if (max_q == '0) begin
            sc_q[k_q[1:0]] <= '0;
          end else begin
            sc_q[k_q[1:0]] <= dneg_q[k_q[1:0]] ? -div_quo[31:0] : div_quo[31:0];
          end
        end
        DV_T1:   dur_q[0] <= sat32(qv64);
        DV_T2:   dur_q[1] <= sat32(qv64 - d0_64);
        default: dur_q[2] <= sat32(qv64 - (d0_64 <<< 1) - d1_64);
      endcase
    end
    if (state_q == F_JAX) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        jax_q[i] <= mulq($signed({1'b0, jerk_limit_i}), $signed(sc_q[i]), FRAC_BITS);
      end
    end
    if (state_q == F_J6) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        jax6_q[i] <= div6($signed(jax_q[i]));
      end
    end
  end

  assign job_o = '{pos: pos_q, jax: jax_q, jax6: jax6_q, dur: dur_q};

endmodule

// ----- rtl/jlp_fifo.sv -----
// Short queue of planned jobs between intake and coefficient generation.
module jlp_fifo import jlp_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t data_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/jlp_back.sv -----
// Segment sequencer: emits coefficients and advances each axis state.
module jlp_back import jlp_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  job_t        job_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  segment_o,
  output logic [1:0]  axis_o,
  output logic [31:0] pos_coeff_o,
  output logic [31:0] vel_coeff_o,
  output logic [31:0] acc_coeff_o,
  output logic [31:0] jerk_coeff_o,
  output logic [31:0] duration_o,
  output logic        last_o
);

  back_e state_q, state_d;
  job_t  job_q;
  vec3_t pos_q, vel_q, acc_q;
  logic [2:0] seg_q;
  logic [1:0] ax_q;
  logic signed [31:0] tt_q, ttt_q;
  logic signed [31:0] r1_q, r2_q, r3_q, r4_q, r5_q, r6_q;
  logic signed [31:0] r2h_q, r3s_q, r5h_q;
  logic out_valid_q, load_out;

  logic signed [31:0] t, j, j6, p, v, a, jax, jax6;
  logic signed [34:0] np, nv, na;

  assign t    = $signed(job_q.dur[dur_sel(seg_q)]);
  assign jax  = $signed(job_q.jax[ax_q]);
  assign jax6 = $signed(job_q.jax6[ax_q]);
  assign p    = $signed(pos_q[ax_q]);
  assign v    = $signed(vel_q[ax_q]);
  assign a    = $signed(acc_q[ax_q]);

  always_comb begin
    case (jerk_sign(seg_q))
      JS_POS: begin
        j  = jax;
        j6 = jax6;
      end
      JS_NEG: begin
        j  = (jax == Q_MIN) ? Q_MAX : -jax;
        j6 = -jax6;
      end
      default: begin
        j  = '0;
        j6 = '0;
      end
    endcase
  end

  assign np = 35'(p) + 35'(r1_q) + 35'(r2h_q) + 35'(r3s_q);
  assign nv = 35'(v) + 35'(r4_q) + 35'(r5h_q);
  assign na = 35'(a) + 35'(r6_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (!empty_i) begin
        state_d = B_TT;
      end
      B_TT:  state_d = B_TTT;
      B_TTT: state_d = B_MUL;
      B_MUL: if (load_out) begin
        state_d = B_DIV;
      end
      B_DIV: state_d = B_ADD;
      B_ADD: begin
        if (ax_q != AX_LAST) begin
          state_d = B_MUL;
        end else if (seg_q == SEG_LAST) begin
          state_d = B_IDLE;
        end else begin
          state_d = B_TT;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = (state_q == B_IDLE) && !empty_i;
    load_out = (state_q == B_MUL) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      seg_q       <= '0;
      ax_q        <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        seg_q <= '0;
        ax_q  <= '0;
      end else if (state_q == B_ADD) begin
        if (ax_q != AX_LAST) begin
          ax_q <= ax_q + 2'd1;
        end else begin
          ax_q <= '0;
          if (seg_q != SEG_LAST) begin
            seg_q <= seg_q + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
      pos_q <= job_i.pos;
      vel_q <= '0;
      acc_q <= '0;
    end
    if (state_q == B_TT) begin
      tt_q <= mulq(t, t, FRAC_BITS);
    end
    if (state_q == B_TTT) begin
      ttt_q <= mulq(tt_q, t, FRAC_BITS);
    end
    if (load_out) begin
      r1_q         <= mulq(v, t, FRAC_BITS);
      r2_q         <= mulq(a, tt_q, FRAC_BITS);
      r3_q         <= mulq(j, ttt_q, FRAC_BITS);
      r4_q         <= mulq(a, t, FRAC_BITS);
      r5_q         <= mulq(j, tt_q, FRAC_BITS);
      r6_q         <= mulq(j, t, FRAC_BITS);
      segment_o    <= seg_q;
      axis_o       <= ax_q;
      pos_coeff_o  <= p;
      vel_coeff_o  <= v;
      acc_coeff_o  <= half(a);
      jerk_coeff_o <= j6;
      duration_o   <= t;
      last_o       <= (seg_q == SEG_LAST) && (ax_q == AX_LAST);
    end
    if (state_q == B_DIV) begin
      r2h_q <= half(r2_q);
      r3s_q <= div6(r3_q);
      r5h_q <= half(r5_q);
    end
    if (state_q == B_ADD) begin
      pos_q[ax_q] <= sat32(64'(np));
      vel_q[ax_q] <= sat32(64'(nv));
      acc_q[ax_q] <= sat32(64'(na));
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/jlp_checker.sv -----
// Port-level checks on the line profile block, bound to its top level.
`include "jerk_limited_line_profile_defines.svh"

module jlp_checker import jlp_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cfg_we_i,
  input logic [1:0]       cfg_idx_i,
  input logic [CFG_W-1:0] cfg_data_i,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [31:0]      start_x_i,
  input logic [31:0]      start_y_i,
  input logic [31:0]      start_z_i,
  input logic [31:0]      end_x_i,
  input logic [31:0]      end_y_i,
  input logic [31:0]      end_z_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [2:0]       segment_o,
  input logic [1:0]       axis_o,
  input logic [31:0]      pos_coeff_o,
  input logic [31:0]      vel_coeff_o,
  input logic [31:0]      acc_coeff_o,
  input logic [31:0]      jerk_coeff_o,
  input logic [31:0]      duration_o,
  input logic             last_o
);

  `JLP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `JLP_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(pos_coeff_o) && $stable(segment_o) && $stable(axis_o) && $stable(duration_o))
  `JLP_ASSERT_NOW(a_out_range, out_valid_o, segment_o <= SEG_LAST && axis_o <= AX_LAST)
  `JLP_ASSERT_NOW(a_last_pos, out_valid_o && last_o, segment_o == SEG_LAST && axis_o == AX_LAST)
  `JLP_ASSERT_NEXT(a_in_fill, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind jerk_limited_line_profile jlp_checker u_jlp_checker (.*);

// ----- bench/jlp_checker.sv -----
// Watches the line profile channels, predicts every result and compares.
`timescale 1ns / 1ps
module jlp_scoreboard import jlp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [31:0]      start_x_i,
  input  logic [31:0]      start_y_i,
  input  logic [31:0]      start_z_i,
  input  logic [31:0]      end_x_i,
  input  logic [31:0]      end_y_i,
  input  logic [31:0]      end_z_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [2:0]       segment_i,
  input  logic [1:0]       axis_i,
  input  logic [31:0]      pos_coeff_i,
  input  logic [31:0]      vel_coeff_i,
  input  logic [31:0]      acc_coeff_i,
  input  logic [31:0]      jerk_coeff_i,
  input  logic [31:0]      duration_i,
  input  logic             last_i,
  output int               errors_o,
  output int               pending_o,
  output int               results_o
);

  typedef struct packed {
    logic [2:0]  seg;
    logic [1:0]  ax;
    logic [31:0] pos;
    logic [31:0] vel;
    logic [31:0] acc;
    logic [31:0] jrk;
    logic [31:0] dur;
    logic        last;
  } coeff_t;

  localparam longint QONE = 64'sd65536;

  coeff_t coeff_q[$];
  longint vel_lim  = 131072;
  longint acc_lim  = 65536;
  longint jerk_lim = 262144;
  int     mismatches = 0;

  assign errors_o  = mismatches;
  assign pending_o = coeff_q.size();

  function automatic int clamp32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return int'(x);
  endfunction

  function automatic int qmul(input int a, input int b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp32(p / QONE);
  endfunction

  function automatic longint safe_quot(input longint num, input longint den);
    if (den == 0) return 64'sd2147483647;
    return num / den;
  endfunction

  task automatic plan_profile(input logic [31:0] s_in[3], input logic [31:0] e_in[3]);
    int     p[3], v[3], a[3], jax[3], dur[3];
    longint disp[3];
    longint maxabs, ad, np, nv, na;
    int     t, tt, ttt, j, sc, n, sgn, sel;
    coeff_t c;
    maxabs = 0;
    n = 0;
    for (int i = 0; i < 3; i++) begin
      disp[i] = longint'($signed(e_in[i])) - longint'($signed(s_in[i]));
      ad = disp[i] < 0 ? -disp[i] : disp[i];
      if (ad > maxabs) maxabs = ad;
      p[i] = $signed(s_in[i]);
      v[i] = 0;
      a[i] = 0;
    end
    for (int i = 0; i < 3; i++) begin
      sc = 0;
      if (maxabs != 0) sc = clamp32((disp[i] * QONE) / maxabs);
      jax[i] = qmul(int'(jerk_lim), sc);
    end
    dur[0] = clamp32(safe_quot(acc_lim * QONE, jerk_lim));
    dur[1] = clamp32(safe_quot(vel_lim * QONE, acc_lim) - longint'(dur[0]));
    dur[2] = clamp32(safe_quot(maxabs * QONE, vel_lim) - 2 * longint'(dur[0])
                     - longint'(dur[1]));
    for (int k = 0; k < 7; k++) begin
      case (jerk_sign(3'(k)))
        JS_POS:  sgn = 1;
        JS_NEG:  sgn = -1;
        default: sgn = 0;
      endcase
      case (dur_sel(3'(k)))
        DUR_T2:  sel = 1;
        DUR_T4:  sel = 2;
        default: sel = 0;
      endcase
      t = dur[sel];
      tt = qmul(t, t);
      ttt = qmul(tt, t);
      for (int i = 0; i < 3; i++) begin
        j = clamp32(longint'(sgn) * longint'(jax[i]));
        c.seg  = 3'(k);
        c.ax   = 2'(i);
        c.pos  = p[i];
        c.vel  = v[i];
        c.acc  = a[i] / 2;
        c.jrk  = j / 6;
        c.dur  = t;
        c.last = (n == 20);
        coeff_q.push_back(c);
        n++;
        np = longint'(p[i]) + longint'(qmul(v[i], t)) + longint'(qmul(a[i], tt) / 2)
             + longint'(qmul(j, ttt) / 6);
        nv = longint'(v[i]) + longint'(qmul(a[i], t)) + longint'(qmul(j, tt) / 2);
        na = longint'(a[i]) + longint'(qmul(j, t));
        p[i] = clamp32(np);
        v[i] = clamp32(nv);
        a[i] = clamp32(na);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    coeff_t exp_c;
    coeff_t got;
    if (!rst_ni) begin
      vel_lim  = 131072;
      acc_lim  = 65536;
      jerk_lim = 262144;
      results_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_VEL:  vel_lim  = longint'(cfg_data_i);
          CFG_ACC:  acc_lim  = longint'(cfg_data_i);
          CFG_JERK: jerk_lim = longint'(cfg_data_i);
          default:  ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        results_o <= results_o + 1;
        got = '{segment_i, axis_i, pos_coeff_i, vel_coeff_i, acc_coeff_i, jerk_coeff_i,
                duration_i, last_i};
        if (coeff_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer: %p", got);
        end else begin
          exp_c = coeff_q.pop_front();
          if (got !== exp_c) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch seg %0d axis %0d", exp_c.seg, exp_c.ax);
              $display("  expected %p", exp_c);
              $display("  actual   %p", got);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        plan_profile('{start_x_i, start_y_i, start_z_i}, '{end_x_i, end_y_i, end_z_i});
    end
  end

endmodule

// ----- bench/testbench.sv -----
// Top of the line profile bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench import jlp_pkg::*;;

  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int LIMIT = 1000000;
  localparam logic [30:0] LIM_MAX = 31'h7FFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = CFG_VEL;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] sx = '0, sy = '0, sz = '0, ex = '0, ey = '0, ez = '0;
  logic out_valid, out_stall = 1'b0;
  logic [2:0] seg;
  logic [1:0] ax;
  logic [31:0] pos_c, vel_c, acc_c, jrk_c, dur_c;
  logic last;
  int errors, pending, results;
  int sent = 0;
  int cycles = 0;
  int burst_left = 0;
  bit hold_req = 0;
  int hold_cnt = 0;
  int stall_mode = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  jerk_limited_line_profile dut (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .start_x_i(sx), .start_y_i(sy), .start_z_i(sz), .end_x_i(ex), .end_y_i(ey), .end_z_i(ez),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .segment_o(seg), .axis_o(ax),
    .pos_coeff_o(pos_c), .vel_coeff_o(vel_c), .acc_coeff_o(acc_c), .jerk_coeff_o(jrk_c),
    .duration_o(dur_c), .last_o(last)
  );

  jlp_scoreboard u_scoreboard (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .start_x_i(sx), .start_y_i(sy), .start_z_i(sz), .end_x_i(ex), .end_y_i(ey), .end_z_i(ez),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .segment_i(seg), .axis_i(ax),
    .pos_coeff_i(pos_c), .vel_coeff_i(vel_c), .acc_coeff_i(acc_c), .jerk_coeff_i(jrk_c),
    .duration_i(dur_c), .last_i(last), .errors_o(errors), .pending_o(pending),
    .results_o(results)
  );

  // receiver: hold off on request, otherwise stall by the current pattern
  always @(posedge clk_i) begin
    if (hold_req && hold_cnt == 0) begin
      hold_cnt = 600;
      hold_req = 0;
    end
    if (cycles % 250 == 0) stall_mode = $urandom_range(0, 3);
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 9) < 3);
        2:       out_stall <= ((cycles % 7) < 3);
        default: out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send(input logic [31:0] a, b, c, d, e, f);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 40)) @(posedge clk_i);
      burst_left = $urandom_range(1, 5);
    end
    in_valid <= 1'b1;
    {sx, sy, sz, ex, ey, ez} <= {a, b, c, d, e, f};
    do @(posedge clk_i); while (in_stall);
    burst_left--;
    sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_limits(input logic [30:0] v, a, j);
    @(posedge clk_i);
    cfg_we <= 1'b1; cfg_idx <= CFG_VEL; cfg_data <= v;
    @(posedge clk_i);
    cfg_idx <= CFG_ACC; cfg_data <= a;
    @(posedge clk_i);
    cfg_idx <= CFG_JERK; cfg_data <= j;
    @(posedge clk_i);
    cfg_idx <= CFG_SPARE; cfg_data <= 31'($urandom);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic random_items(input int count);
    logic [31:0] s[3], d[3];
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
        s[i] = $urandom;
        if (kind < 5) d[i] = s[i] + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        else if (kind < 8) d[i] = $urandom;
        else d[i] = (i == 0) ? $urandom : s[i];
      end
      send(s[0], s[1], s[2], d[0], d[1], d[2]);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: default limits
    send(0, 0, 0, 0, 0, 0);
    send(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0);
    send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
         32'h8000_0000);
    send(0, 0, 0, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
    send(0, 0, 0, 32'h0003_0000, 32'h0003_0000, 32'h0003_0000);
    send(0, 0, 0, 0, 32'h0005_0000, 0);
    send(0, 0, 0, 0, 0, 32'hFFF0_0000);
    send(32'h1234_5678, 32'hFFFF_FFFF, 0, 32'h1234_5679, 32'hFFFF_FFFF, 1);
    send(0, 32'h8000_0000, 0, 32'h0100_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hAAAA_AAAA, 32'h5555_5555,
         32'hF0F0_F0F0);
    drain();
    set_limits(LIM_MAX, LIM_MAX, LIM_MAX);
    send(0, 0, 0, 0, 0, 0);
    send(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0);
    send(0, 0, 0, 32'h0010_0000, 32'h0008_0000, 32'hFFF8_0000);
    drain();
    set_limits(1, 1, 1);
    send(0, 0, 0, 32'h0002_0000, 0, 0);
    send(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 1, 0);
    drain();
    set_limits(0, 0, 0);
    send(0, 0, 0, 32'h0002_0000, 32'h0001_0000, 0);
    send(0, 0, 0, 0, 0, 0);
    random_items(20);
    drain();
    // long output hold-off with requests still arriving
    set_limits(31'h0002_0000, 31'h0001_0000, 31'h0004_0000);
    hold_req = 1;
    burst_left = 8;
    random_items(10);
    drain();
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0:       set_limits(31'h0004_0000, 31'h0002_0000, 31'h0001_0000);
        1:       set_limits(31'h0000_8000, 31'h0010_0000, 31'h0100_0000);
        2:       set_limits(LIM_MAX, 1, 31'h4000_0000);
        default: set_limits(31'($urandom_range(1, 1 << 22)), 31'($urandom_range(1, 1 << 22)),
                            31'($urandom));
      endcase
      random_items(45);
      drain();
    end
    repeat (200) @(posedge clk_i);
    $display("Covered %0d requests and %0d coefficient results over several limit settings,",
             sent, results);
    $display("including zero and full-scale limits, ties, zero and extreme displacements.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
